// ----- hdl/gbl_pkg.sv -----
// Package for the GNSS binary log framer: constants, codes and the result beat type.
`default_nettype none
package gbl_pkg;

  localparam int CRC_BYTES          = 4;
  localparam int SHORT_HEADER_BYTES = 12;
  localparam int LONG_MIN_HEADER    = 10;

  localparam logic [15:0] MAX_FRAME_RESET = 16'd4096;

  localparam logic [7:0] SYNC1_BYTE      = 8'hAA;
  localparam logic [7:0] SYNC2_BYTE      = 8'h44;
  localparam logic [7:0] SYNC3_LONG_BYTE = 8'h12;
  localparam logic [7:0] SYNC3_SHRT_BYTE = 8'h13;

  localparam logic [15:0] OFF_HDR_LEN  = 16'd3;
  localparam logic [15:0] OFF_BODY_LO  = 16'd8;
  localparam logic [15:0] OFF_BODY_HI  = 16'd9;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_SYNC3 = 3'd2,
    PH_HEAD  = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DISCARD = 3'd0,
    KIND_SYNC    = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_BODY    = 3'd3,
    KIND_CRC     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_offset;
    kind_e       byte_kind;
    logic        long_form;
    logic        frame_last;
    logic        frame_abort;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/gnss_binary_log_framer.sv -----
// Top level of the GNSS binary log framer.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o   rx_byte_i
//   out      out  out_valid_o/out_stall_i data_byte_o, frame_offset_o, byte_kind_o,
//                                         long_form_o, frame_last_o, frame_abort_o
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (max_frame_bytes)
//
// One beat in, one beat out; a new byte is taken every cycle while the output is not stalled.
// Each byte passes the input register, then the framing step into the result register.
// Reset clears the framing state and sets max_frame_bytes to 4096.
// A stall on the output holds the result register and, in the same cycle, the input register.
`default_nettype none
module gnss_binary_log_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      frame_offset_o,
  output logic [2:0]       byte_kind_o,
  output logic             long_form_o,
  output logic             frame_last_o,
  output logic             frame_abort_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic             res_ready;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             step;
  logic [15:0]      max_frame_q;
  gbl_pkg::result_t step_res;
  gbl_pkg::result_t out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= gbl_pkg::MAX_FRAME_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_frame_q <= cfg_data_i;
    end
  end

  gbl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .adv_i      (res_ready),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte)
  );

  assign step = s1_valid && res_ready;

  gbl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (s1_byte),
    .max_frame_i (max_frame_q),
    .res_o       (step_res)
  );

  gbl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (step_res),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign data_byte_o    = out_res.data_byte;
  assign frame_offset_o = out_res.frame_offset;
  assign byte_kind_o    = out_res.byte_kind;
  assign long_form_o    = out_res.long_form;
  assign frame_last_o   = out_res.frame_last;
  assign frame_abort_o  = out_res.frame_abort;

endmodule
`default_nettype wire

// ----- hdl/gbl_in_reg.sv -----
// Input register stage: holds one received byte until the framing step takes it.
`default_nettype none
module gbl_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            in_stall_o,
  input  wire logic       adv_i,
  output logic            s1_valid_o,
  output logic [7:0]      s1_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;

endmodule
`default_nettype wire

// ----- hdl/gbl_core.sv -----
// Framing state machine: tags one byte per step and tracks frame length.
`default_nettype none
module gbl_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] max_frame_i,
  output gbl_pkg::result_t res_o
);

  gbl_pkg::phase_e phase_q, phase_d;
  logic [15:0]     count_q, count_d;
  logic [7:0]      hdr_q, hdr_d;
  logic [15:0]     body_q, body_d;
  logic            long_q, long_d;
  logic [16:0]     total_q, total_d;

  logic            clear;
  logic            len_chk;
  logic [16:0]     len_total;
  logic [16:0]     off_ext;
  logic [16:0]     body_end;

  assign off_ext  = {1'b0, count_q};
  assign body_end = {9'b0, hdr_q} + {1'b0, body_q};

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    hdr_d     = hdr_q;
    body_d    = body_q;
    long_d    = long_q;
    total_d   = total_q;
    clear     = 1'b0;
    len_chk   = 1'b0;
    len_total = '0;

    res_o.data_byte    = rx_byte_i;
    res_o.frame_offset = '0;
    res_o.byte_kind    = gbl_pkg::KIND_DISCARD;
    res_o.long_form    = 1'b0;
    res_o.frame_last   = 1'b0;
    res_o.frame_abort  = 1'b0;

    unique case (phase_q)
      gbl_pkg::PH_SYNC2: begin
        if (rx_byte_i == gbl_pkg::SYNC2_BYTE) begin
          res_o.byte_kind    = gbl_pkg::KIND_SYNC;
          res_o.frame_offset = 16'd1;
          count_d            = 16'd2;
          phase_d            = gbl_pkg::PH_SYNC3;
        end else begin
          res_o.frame_abort = 1'b1;
          clear             = 1'b1;
        end
      end
      gbl_pkg::PH_SYNC3: begin
        if (rx_byte_i == gbl_pkg::SYNC3_LONG_BYTE || rx_byte_i == gbl_pkg::SYNC3_SHRT_BYTE) begin
          long_d             = (rx_byte_i == gbl_pkg::SYNC3_LONG_BYTE);
          res_o.byte_kind    = gbl_pkg::KIND_SYNC;
          res_o.frame_offset = 16'd2;
          res_o.long_form    = long_d;
          count_d            = 16'd3;
          phase_d            = gbl_pkg::PH_HEAD;
        end else begin
          res_o.frame_abort = 1'b1;
          clear             = 1'b1;
        end
      end
      gbl_pkg::PH_HEAD: begin
        res_o.frame_offset = count_q;
        res_o.byte_kind    = gbl_pkg::KIND_HEADER;
        res_o.long_form    = long_q;
        count_d            = count_q + 16'd1;
        if (long_q) begin
          if (count_q == gbl_pkg::OFF_HDR_LEN) begin
            hdr_d = rx_byte_i;
            if (rx_byte_i < 8'(gbl_pkg::LONG_MIN_HEADER)) begin
              res_o.frame_abort = 1'b1;
              clear             = 1'b1;
            end
          end else if (count_q == gbl_pkg::OFF_BODY_LO) begin
            body_d[7:0] = rx_byte_i;
          end else if (count_q == gbl_pkg::OFF_BODY_HI) begin
            body_d[15:8] = rx_byte_i;
            len_chk      = 1'b1;
          end
        end else if (count_q == gbl_pkg::OFF_HDR_LEN) begin
          body_d  = {8'b0, rx_byte_i};
          hdr_d   = 8'(gbl_pkg::SHORT_HEADER_BYTES);
          len_chk = 1'b1;
        end
        if (len_chk) begin
          len_total = {9'b0, hdr_d} + {1'b0, body_d} + 17'(gbl_pkg::CRC_BYTES);
          if (len_total > {1'b0, max_frame_i} || len_total <= off_ext) begin
            res_o.frame_abort = 1'b1;
            clear             = 1'b1;
          end else if (len_total == off_ext + 17'd1) begin
            res_o.frame_last = 1'b1;
            clear            = 1'b1;
          end else begin
            phase_d = gbl_pkg::PH_BODY;
            total_d = len_total;
          end
        end
      end
      gbl_pkg::PH_BODY: begin
        res_o.frame_offset = count_q;
        res_o.long_form    = long_q;
        if (off_ext < {9'b0, hdr_q}) begin
          res_o.byte_kind = gbl_pkg::KIND_HEADER;
        end else if (off_ext < body_end) begin
          res_o.byte_kind = gbl_pkg::KIND_BODY;
        end else begin
          res_o.byte_kind = gbl_pkg::KIND_CRC;
        end
        count_d = count_q + 16'd1;
        if (off_ext + 17'd1 >= total_q) begin
          res_o.frame_last = 1'b1;
          clear            = 1'b1;
        end
      end
      default: begin
        if (rx_byte_i == gbl_pkg::SYNC1_BYTE) begin
          res_o.byte_kind = gbl_pkg::KIND_SYNC;
          count_d         = 16'd1;
          phase_d         = gbl_pkg::PH_SYNC2;
        end else begin
          phase_d = gbl_pkg::PH_SYNC1;
        end
      end
    endcase

    if (clear) begin
      phase_d = gbl_pkg::PH_SYNC1;
      count_d = '0;
      hdr_d   = '0;
      body_d  = '0;
      long_d  = 1'b0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gbl_pkg::PH_SYNC1;
      count_q <= '0;
      hdr_q   <= '0;
      body_q  <= '0;
      long_q  <= 1'b0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      hdr_q   <= hdr_d;
      body_q  <= body_d;
      long_q  <= long_d;
      total_q <= total_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gbl_out_reg.sv -----
// Result register: holds one tagged beat until the downstream side takes it.
`default_nettype none
module gbl_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire gbl_pkg::result_t res_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gbl_pkg::result_t      res_o
);

  logic             valid_q, valid_d;
  gbl_pkg::result_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ----- hdl/gbl_checker.sv -----
// Port-level assertions for the GNSS binary log framer, bound to the top level.
`default_nettype none
module gbl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  data_byte_o,
  input wire logic [15:0] frame_offset_o,
  input wire logic [2:0]  byte_kind_o,
  input wire logic        long_form_o,
  input wire logic        frame_last_o,
  input wire logic        frame_abort_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(frame_offset_o) && $stable(byte_kind_o) && $stable(frame_last_o))
    else $error("stalled output beat changed");

  a_last_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_last_o && frame_abort_o))
    else $error("beat marked both last and abort");

  a_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == gbl_pkg::KIND_DISCARD
      |-> frame_offset_o == 16'd0 && !long_form_o && !frame_last_o)
    else $error("discarded beat carries frame tags");

  a_first_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == gbl_pkg::KIND_SYNC && frame_offset_o == 16'd0
      |-> data_byte_o == gbl_pkg::SYNC1_BYTE && !long_form_o)
    else $error("frame opened on wrong sync byte");

  a_last_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o && gbl_pkg::CRC_BYTES != 0
      |-> byte_kind_o == gbl_pkg::KIND_CRC)
    else $error("frame ended outside the crc");

endmodule

bind gnss_binary_log_framer gbl_checker u_gbl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .data_byte_o    (data_byte_o),
  .frame_offset_o (frame_offset_o),
  .byte_kind_o    (byte_kind_o),
  .long_form_o    (long_form_o),
  .frame_last_o   (frame_last_o),
  .frame_abort_o  (frame_abort_o)
);
`default_nettype wire
